>>> rtl/core/lr_pkg.sv
// shared types and constants for the line rasterizer
// no dependencies; used by every module in rtl/core

package lr_pkg;

    localparam int COORD_W       = 6;
    localparam int COLOR_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int S_DATA_W      = 56;
    localparam int M_DATA_W      = 48;
    localparam int TILE_SPAN_DEF = 64;

    typedef logic [COORD_W-1:0] coord_t;

    // segment after endpoint sorting
    typedef struct packed {
        logic                      steep;
        coord_t                    major_start;
        coord_t                    minor_start;
        coord_t                    len;
        logic signed [DIFF_W-1:0]  minor_diff;
    } lr_setup_t;

    // one step of the error accumulator
    typedef struct packed {
        coord_t rem_next;
        logic   minor_up;
        logic   minor_down;
    } lr_step_t;

endpackage

>>> rtl/core/line_rasterizer.sv
// Line rasterizer: takes one segment per request (two endpoints in the tile and a
// color) and emits every pixel of it, one per cycle while the output is not stalled,
// ordered along the major axis, with tlast on the final pixel. Coordinates above
// TILE_SPAN-1 are clamped. The endpoint sort is done on the accepting clock edge;
// after that a single shared add/compare unit walks the exact floor of the
// interpolation one pixel per cycle, pausing whenever the output is stalled.
// The input is not ready while a segment is being walked; the final pixel may
// still wait in the output register while the next segment is accepted.

module line_rasterizer
    import lr_pkg::*;
#(
    parameter int TILE_SPAN = TILE_SPAN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pixel_color[55:24]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_value[43:12], zero above
    output logic [M_DATA_W-1:0] m_tdata,
    // final_pixel
    output logic                m_tlast
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                   state_reg;
    logic                     steep_reg;
    coord_t                   major_reg;
    coord_t                   minor_reg;
    coord_t                   rem_reg;
    coord_t                   len_reg;
    coord_t                   cnt_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [COLOR_W-1:0]       color_reg;
    logic                     out_valid_reg;
    coord_t                   out_x_reg;
    coord_t                   out_y_reg;
    logic [COLOR_W-1:0]       out_color_reg;
    logic                     out_last_reg;

    lr_setup_t seg;
    lr_step_t  step;
    logic      accept;
    logic      load;

    lr_setup #(
        .TILE_SPAN (TILE_SPAN)
    ) u_setup (
        .start_x (s_tdata[COORD_W-1:0]),
        .start_y (s_tdata[2*COORD_W-1:COORD_W]),
        .end_x   (s_tdata[3*COORD_W-1:2*COORD_W]),
        .end_y   (s_tdata[4*COORD_W-1:3*COORD_W]),
        .seg     (seg)
    );

    lr_err_unit u_err (
        .rem        (rem_reg),
        .minor_diff (diff_reg),
        .len        (len_reg),
        .step       (step)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_RUN) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - COLOR_W - 2*COORD_W){1'b0}},
                       out_color_reg, out_y_reg, out_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        steep_reg <= seg.steep;
                        major_reg <= seg.major_start;
                        minor_reg <= seg.minor_start;
                        len_reg   <= seg.len;
                        cnt_reg   <= seg.len;
                        diff_reg  <= seg.minor_diff;
                        rem_reg   <= '0;
                        color_reg <= s_tdata[4*COORD_W+COLOR_W-1:4*COORD_W];
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (load) begin
                        out_x_reg     <= steep_reg ? minor_reg : major_reg;
                        out_y_reg     <= steep_reg ? major_reg : minor_reg;
                        out_color_reg <= color_reg;
                        out_last_reg  <= (cnt_reg == '0);
                        major_reg     <= major_reg + 1'b1;
                        rem_reg       <= step.rem_next;
                        cnt_reg       <= cnt_reg - 1'b1;
                        if (step.minor_up) begin
                            minor_reg <= minor_reg + 1'b1;
                        end else if (step.minor_down) begin
                            minor_reg <= minor_reg - 1'b1;
                        end
                        if (cnt_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_RUN))
        else $error("accepted segment did not start a walk");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg <= len_reg))
        else $error("pixel count exceeds segment length");

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (rem_reg < len_reg || len_reg == '0))
        else $error("interpolation remainder out of range");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cnt_reg == '0) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final pixel did not end the walk");
`endif

endmodule

>>> rtl/core/lr_setup.sv
// endpoint clamping, axis choice and ordering for one segment
// depends on lr_pkg

module lr_setup
    import lr_pkg::*;
#(
    parameter int TILE_SPAN = TILE_SPAN_DEF
) (
    input  coord_t    start_x,
    input  coord_t    start_y,
    input  coord_t    end_x,
    input  coord_t    end_y,
    output lr_setup_t seg
);

    localparam int     LimInt   = (TILE_SPAN - 1 < (1 << COORD_W) - 1) ?
                                  TILE_SPAN - 1 : (1 << COORD_W) - 1;
    localparam coord_t CoordLim = COORD_W'(LimInt);

    coord_t x0, y0, x1, y1;
    coord_t dx, dy;
    coord_t ma, na, mb, nb;
    coord_t m_lo, n_lo, m_hi, n_hi;
    logic   steep;

    always_comb begin
        x0 = (start_x > CoordLim) ? CoordLim : start_x;
        y0 = (start_y > CoordLim) ? CoordLim : start_y;
        x1 = (end_x   > CoordLim) ? CoordLim : end_x;
        y1 = (end_y   > CoordLim) ? CoordLim : end_y;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = dx < dy;
        if (steep) begin
            ma = y0; na = x0; mb = y1; nb = x1;
        end else begin
            ma = x0; na = y0; mb = x1; nb = y1;
        end
        if (ma > mb) begin
            m_lo = mb; n_lo = nb; m_hi = ma; n_hi = na;
        end else begin
            m_lo = ma; n_lo = na; m_hi = mb; n_hi = nb;
        end
        seg.steep       = steep;
        seg.major_start = m_lo;
        seg.minor_start = n_lo;
        seg.len         = m_hi - m_lo;
        seg.minor_diff  = $signed({1'b0, n_hi}) - $signed({1'b0, n_lo});
    end

endmodule

>>> rtl/core/lr_err_unit.sv
// shared add/compare unit that advances the interpolation remainder by one step
// depends on lr_pkg

module lr_err_unit
    import lr_pkg::*;
(
    input  coord_t                   rem,
    input  logic signed [DIFF_W-1:0] minor_diff,
    input  coord_t                   len,
    output lr_step_t                 step
);

    logic signed [DIFF_W:0] sum;
    logic signed [DIFF_W:0] len_s;

    always_comb begin
        sum   = $signed({2'b00, rem}) + $signed({minor_diff[DIFF_W-1], minor_diff});
        len_s = $signed({2'b00, len});
        step.minor_up   = 1'b0;
        step.minor_down = 1'b0;
        step.rem_next   = sum[COORD_W-1:0];
        // remainder stays in [0, len); |minor_diff| <= len keeps one correction enough
        priority if (len == '0) begin
            step.rem_next = '0;
        end else if (sum >= len_s) begin
            step.minor_up = 1'b1;
            step.rem_next = COORD_W'(sum - len_s);
        end else if (sum < 0) begin
            step.minor_down = 1'b1;
            step.rem_next   = COORD_W'(sum + len_s);
        end
    end

endmodule

>>> test/line_rasterizer_tb.sv
// testbench for line_rasterizer: streams directed and random segments through the block
// and checks every emitted pixel against a floor-exact interpolation kept in the bench
// depends on lr_pkg and line_rasterizer from rtl/core
`timescale 1ns / 100ps

module line_rasterizer_tb;
    import lr_pkg::*;

    localparam int TILE_SPAN       = TILE_SPAN_DEF;
    localparam int RANDOM_SEGMENTS = 290;
    localparam int HOLD_AT         = 40;
    localparam int HOLD_CYCLES     = 500;
    localparam int DRAIN_CYCLES    = 100;
    localparam int CYCLE_LIMIT     = 600000;

    // fields packed from the top down so start_x lands in the low bits
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        coord_t             end_y;
        coord_t             end_x;
        coord_t             start_y;
        coord_t             start_x;
    } segment_t;

    typedef struct packed {
        coord_t             x;
        coord_t             y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    segment_t pending_segments[$];
    pixel_t   expected_pixels[$];
    int       segments_accepted = 0;
    int       error_count       = 0;
    int       cycle_count       = 0;
    int       burst_left        = 1;
    int       gap_left          = 0;
    int       hold_left         = 0;
    bit       hold_done         = 1'b0;
    int       rx_phase_left     = 0;
    rx_mode_t rx_mode           = RX_ALWAYS;

    line_rasterizer #(.TILE_SPAN(TILE_SPAN)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int to_tile(int v);
        if (v < 0) return 0;
        if (v > 63) return 63;
        return v;
    endfunction

    function automatic segment_t make_segment(int sx, int sy, int ex, int ey,
                                              logic [COLOR_W-1:0] color);
        segment_t seg;
        seg.start_x = coord_t'(sx);
        seg.start_y = coord_t'(sy);
        seg.end_x   = coord_t'(ex);
        seg.end_y   = coord_t'(ey);
        seg.color   = color;
        return seg;
    endfunction

    // queues every pixel of one segment, walking the major axis upward
    function automatic void rasterize_segment(segment_t seg);
        int     x0, y0, x1, y1, dx, dy;
        int     ma, na, mb, nb, len, d, k, num, minor, t;
        bit     steep;
        pixel_t px;
        x0 = (seg.start_x > TILE_SPAN - 1) ? TILE_SPAN - 1 : seg.start_x;
        y0 = (seg.start_y > TILE_SPAN - 1) ? TILE_SPAN - 1 : seg.start_y;
        x1 = (seg.end_x > TILE_SPAN - 1) ? TILE_SPAN - 1 : seg.end_x;
        y1 = (seg.end_y > TILE_SPAN - 1) ? TILE_SPAN - 1 : seg.end_y;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = dx < dy;
        if (steep) begin
            ma = y0; na = x0; mb = y1; nb = x1;
        end else begin
            ma = x0; na = y0; mb = x1; nb = y1;
        end
        if (ma > mb) begin
            t = ma; ma = mb; mb = t;
            t = na; na = nb; nb = t;
        end
        len = mb - ma;
        d   = nb - na;
        for (k = 0; k <= len; k++) begin
            if (len == 0) begin
                minor = na;
            end else begin
                num = na * len + d * k;
                if (num < 0) num = 0;
                minor = num / len;
            end
            px.x     = coord_t'(steep ? minor : ma + k);
            px.y     = coord_t'(steep ? ma + k : minor);
            px.color = seg.color;
            px.last  = (k == len);
            expected_pixels.push_back(px);
        end
    endfunction

    function automatic segment_t random_segment();
        int a, b, span, lo, c, r;
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        r = $urandom_range(0, 9);
        case (r)
            4: return make_segment(a, c, b, c, $urandom);
            5: return make_segment(c, a, c, b, $urandom);
            6, 9: begin
                span = (a > b) ? a - b : b - a;
                // one step off the diagonal on either side
                if (r == 9) span = (span == 63 || (span > 0 && $urandom_range(0, 1)))
                                   ? span - 1 : span + 1;
                lo = $urandom_range(0, 63 - span);
                if ($urandom_range(0, 1)) return make_segment(a, lo, b, lo + span, $urandom);
                return make_segment(a, lo + span, b, lo, $urandom);
            end
            7: return make_segment(a, c, to_tile(a + $urandom_range(0, 6) - 3),
                                   to_tile(c + $urandom_range(0, 6) - 3), $urandom);
            8: return make_segment(a, c, a, c, $urandom);
            default: return make_segment(a, b, c, $urandom_range(0, 63), $urandom);
        endcase
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // request driver: bursts of segments with random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rasterize_segment(pending_segments[0]);
                pending_segments.delete(0);
                segments_accepted <= segments_accepted + 1;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_segments.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_segments[0];
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0:       gap_left = $urandom_range(1, 70);
                            1:       gap_left = $urandom_range(1, 6);
                            default: gap_left = 0;
                        endcase
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // pixel receiver: stall pattern changes in stretches, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && segments_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       = rx_mode_t'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(20, 200);
            end
            rx_phase_left--;
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN:   m_tready <= $urandom_range(0, 1);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                RX_TOGGLE: m_tready <= ~m_tready;
                default:   m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, actual %0h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("pixel_x", want.x, m_tdata[COORD_W-1:0]);
                compare_field("pixel_y", want.y, m_tdata[2*COORD_W-1:COORD_W]);
                compare_field("pixel_value", want.color,
                              m_tdata[2*COORD_W+COLOR_W-1:2*COORD_W]);
                compare_field("tdata padding", '0, m_tdata[M_DATA_W-1:2*COORD_W+COLOR_W]);
                compare_field("final_pixel", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int i;
        // directed: single points, full-tile spans, diagonals, reversed and steep cases
        pending_segments.push_back(make_segment(0, 0, 0, 0, 32'h0000_0000));
        pending_segments.push_back(make_segment(63, 63, 63, 63, 32'hffff_ffff));
        pending_segments.push_back(make_segment(0, 0, 63, 0, 32'ha5a5_a5a5));
        pending_segments.push_back(make_segment(63, 63, 0, 63, 32'h5a5a_5a5a));
        pending_segments.push_back(make_segment(0, 0, 0, 63, 32'h0000_0001));
        pending_segments.push_back(make_segment(63, 63, 63, 0, 32'h8000_0000));
        pending_segments.push_back(make_segment(0, 0, 63, 63, 32'h1234_5678));
        pending_segments.push_back(make_segment(63, 0, 0, 63, 32'h9abc_def0));
        pending_segments.push_back(make_segment(0, 63, 63, 0, 32'hdead_beef));
        pending_segments.push_back(make_segment(0, 0, 1, 0, 32'h0f0f_0f0f));
        pending_segments.push_back(make_segment(0, 0, 0, 1, 32'hf0f0_f0f0));
        pending_segments.push_back(make_segment(0, 0, 63, 1, 32'h3333_3333));
        pending_segments.push_back(make_segment(63, 1, 0, 0, 32'hcccc_cccc));
        pending_segments.push_back(make_segment(0, 0, 1, 63, 32'h7fff_ffff));
        pending_segments.push_back(make_segment(1, 63, 0, 0, 32'h0000_ffff));
        pending_segments.push_back(make_segment(63, 0, 0, 1, 32'hffff_0000));
        pending_segments.push_back(make_segment(10, 50, 40, 20, 32'h1111_1111));
        pending_segments.push_back(make_segment(40, 20, 10, 50, 32'h2222_2222));
        pending_segments.push_back(make_segment(5, 60, 20, 3, 32'h4444_4444));
        pending_segments.push_back(make_segment(20, 3, 5, 60, 32'h8888_8888));
        pending_segments.push_back(make_segment(0, 0, 62, 63, 32'haaaa_5555));
        pending_segments.push_back(make_segment(63, 0, 0, 62, 32'h5555_aaaa));
        for (i = 0; i < RANDOM_SEGMENTS; i++)
            pending_segments.push_back(random_segment());

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_segments.size() != 0) @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lr_pkg.sv
rtl/core/lr_setup.sv
rtl/core/lr_err_unit.sv
rtl/core/line_rasterizer.sv
test/line_rasterizer_tb.sv
